// ===== rtl/core/obt_pkg.sv =====
package obt_pkg;

  localparam int IN_W  = 16;
  localparam int OUT_W = 18;
  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] THR_RESET = 16'd32;

  // sqrt(L * 2^SQRT_SHIFT) and |v| * 2^(FRAC + NORM_SHIFT) / r
  localparam int SQRT_SHIFT = 20;
  localparam int NORM_SHIFT = 10;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Normalizer depth: squares, sum, one root bit per stage, load, one quotient
  // bit per stage, sign stage.
  function automatic int norm_latency(input int iw, input int frac);
    return iw + frac + 16;
  endfunction

  // Start-to-strobe distance of the whole transform.
  function automatic int obt_latency(input int frac);
    return norm_latency(IN_W, frac) + norm_latency(frac + 2, frac)
         + norm_latency(frac + 3, frac) + 6;
  endfunction

endpackage

// ===== rtl/core/obt_norm.sv =====
module obt_norm import obt_pkg::*; #(
  parameter int FRAC = 14,
  parameter int IW   = 16,
  parameter int SW   = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic signed [IW-1:0]   in_vec [3],
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic signed [FRAC+1:0] out_vec [3],
  output logic                   out_zero,
  output logic [SW-1:0]          out_side
);

  localparam int LW  = 2*IW + 2;
  localparam int XW0 = LW + SQRT_SHIFT;
  localparam int XW  = XW0 + (XW0 % 2);
  localparam int RW  = XW / 2;
  localparam int NW  = IW + FRAC + NORM_SHIFT;
  localparam int CW  = (NW > RW + FRAC) ? NW : RW + FRAC;
  localparam int QW  = FRAC + 1;
  localparam int OW  = FRAC + 2;
  localparam int MT  = SW + 4;  // side, zero flag, three signs

  // Stage A: magnitudes and squares
  logic              a_valid_r;
  logic [MT-1:0]     a_meta_r;
  logic [IW-1:0]     a_mag_r [3];
  logic [2*IW-1:0]   a_sq_r  [3];
  logic [IW-1:0]     a_mag_nxt [3];
  logic [2:0]        a_sgn_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_sgn_nxt[i] = in_vec[i][IW-1];
      a_mag_nxt[i] = in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
    a_meta_r <= {in_side, 1'b0, a_sgn_nxt};
    for (int i = 0; i < 3; i++) begin
      a_mag_r[i] <= a_mag_nxt[i];
      a_sq_r[i]  <= a_mag_nxt[i] * a_mag_nxt[i];
    end
  end

  // Square-root pipeline, one root bit per stage
  logic              sq_valid_r [0:RW];
  logic [MT-1:0]     sq_meta_r  [0:RW];
  logic [IW-1:0]     sq_mag_r   [0:RW][0:2];
  logic [LW-1:0]     sq_len_r   [0:RW];
  logic [RW+1:0]     sq_rem_r   [0:RW];
  logic [RW-1:0]     sq_root_r  [0:RW];
  logic [LW-1:0]     len_nxt;

  assign len_nxt = LW'(a_sq_r[0]) + LW'(a_sq_r[1]) + LW'(a_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r[0] <= 1'b0;
    end else begin
      sq_valid_r[0] <= a_valid_r;
    end
    sq_meta_r[0] <= {a_meta_r[MT-1:4], (len_nxt == '0), a_meta_r[2:0]};
    for (int i = 0; i < 3; i++) begin
      sq_mag_r[0][i] <= a_mag_r[i];
    end
    sq_len_r[0]  <= len_nxt;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [XW-1:0] xf;
    logic [RW+1:0] rsh, trial, rem_nxt;
    logic [RW-1:0] root_nxt;

    assign xf = XW'({sq_len_r[k], {SQRT_SHIFT{1'b0}}});

    always_comb begin
      rsh   = {sq_rem_r[k][RW-1:0], xf[XW-1-2*k -: 2]};
      trial = {sq_root_r[k], 2'b01};
      if (rsh >= trial) begin
        rem_nxt  = rsh - trial;
        root_nxt = {sq_root_r[k][RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rsh;
        root_nxt = {sq_root_r[k][RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k+1] <= 1'b0;
      end else begin
        sq_valid_r[k+1] <= sq_valid_r[k];
      end
      sq_meta_r[k+1] <= sq_meta_r[k];
      for (int i = 0; i < 3; i++) begin
        sq_mag_r[k+1][i] <= sq_mag_r[k][i];
      end
      sq_len_r[k+1]  <= sq_len_r[k];
      sq_rem_r[k+1]  <= rem_nxt;
      sq_root_r[k+1] <= root_nxt;
    end
  end

  // Divider pipeline, one quotient bit per stage for all three components
  logic              dv_valid_r [0:QW];
  logic [MT-1:0]     dv_meta_r  [0:QW];
  logic [RW-1:0]     dv_root_r  [0:QW];
  logic [CW-1:0]     dv_rem_r   [0:QW][0:2];
  logic [QW-1:0]     dv_quo_r   [0:QW][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else begin
      dv_valid_r[0] <= sq_valid_r[RW];
    end
    dv_meta_r[0] <= sq_meta_r[RW];
    dv_root_r[0] <= sq_root_r[RW];
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= CW'({sq_mag_r[RW][i], {(FRAC+NORM_SHIFT){1'b0}}});
      dv_quo_r[0][i] <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = FRAC - j;
    logic [CW-1:0] trial;
    logic [CW-1:0] rem_nxt [3];
    logic [QW-1:0] quo_nxt [3];

    assign trial = CW'(dv_root_r[j]) << B;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = dv_rem_r[j][i];
        quo_nxt[i] = dv_quo_r[j][i];
        if (dv_rem_r[j][i] >= trial) begin
          rem_nxt[i]    = dv_rem_r[j][i] - trial;
          quo_nxt[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[j+1] <= 1'b0;
      end else begin
        dv_valid_r[j+1] <= dv_valid_r[j];
      end
      dv_meta_r[j+1] <= dv_meta_r[j];
      dv_root_r[j+1] <= dv_root_r[j];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[j+1][i] <= rem_nxt[i];
        dv_quo_r[j+1][i] <= quo_nxt[i];
      end
    end
  end

  // Sign stage
  logic                 out_valid_r;
  logic signed [OW-1:0] out_vec_r [3];
  logic                 out_zero_r;
  logic [SW-1:0]        out_side_r;
  logic signed [OW-1:0] qs_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs_nxt[i] = $signed({1'b0, dv_quo_r[QW][i]});
      if (dv_meta_r[QW][3]) begin
        qs_nxt[i] = '0;
      end else if (dv_meta_r[QW][i]) begin
        qs_nxt[i] = -qs_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid_r[QW];
    end
    out_zero_r <= dv_meta_r[QW][3];
    out_side_r <= dv_meta_r[QW][MT-1:4];
    for (int i = 0; i < 3; i++) begin
      out_vec_r[i] <= qs_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_zero  = out_zero_r;
  assign out_side  = out_side_r;
  assign out_vec   = out_vec_r;

endmodule

// ===== rtl/core/orthonormal_basis_transform.sv =====
// Pipeline built around three normalizers, each one square-root bit and one quotient bit a stage.
// Throughput: one word per cycle; busy stays low and the pipeline never stalls.
// Each result is on the out_ ports for one cycle with out_valid high.
// Reset (rst_n low, synchronous) clears all valid bits and sets axis_threshold to 32.
module orthonormal_basis_transform import obt_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_normal_x,
  input  logic signed [IN_W-1:0]  in_normal_y,
  input  logic signed [IN_W-1:0]  in_normal_z,
  input  logic signed [IN_W-1:0]  in_dir_x,
  input  logic signed [IN_W-1:0]  in_dir_y,
  input  logic signed [IN_W-1:0]  in_dir_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_axis_threshold,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic signed [OUT_W-1:0] out_z,
  output logic                    out_degenerate
);

  localparam int VW   = FRAC_BITS + 2;
  localparam int C3W  = FRAC_BITS + 3;
  localparam int HW   = 2*FRAC_BITS + 6;
  localparam int DW   = HW + 2;
  localparam int PXW  = 2*VW;
  localparam int DFW  = PXW + 1;
  localparam int PW   = VW + IN_W;
  localparam int SUMW = PW + 2;

  localparam logic signed [VW:0]     ONE    = (VW+1)'(1) << FRAC_BITS;
  localparam logic [DFW-1:0]         HALF_C = DFW'(1) << (FRAC_BITS - 1);
  localparam logic [SUMW-1:0]        HALF_O = SUMW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(OUT_MAX);
  localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(OUT_MIN);

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } dir_t;

  typedef struct packed {
    logic                 degen;
    dir_t                 d;
    logic signed [VW-1:0] wx;
    logic signed [VW-1:0] wy;
    logic signed [VW-1:0] wz;
  } ctx2_t;

  typedef struct packed {
    ctx2_t                c;
    logic signed [VW-1:0] ux;
    logic signed [VW-1:0] uy;
    logic signed [VW-1:0] uz;
  } ctx3_t;

  function automatic logic signed [C3W-1:0] rnd_cross(input logic signed [DFW-1:0] x);
    logic [DFW-1:0] m;
    logic [DFW-1:0] r;
    m = x[DFW-1] ? DFW'(-x) : DFW'(x);
    r = (m + HALF_C) >> FRAC_BITS;
    return x[DFW-1] ? -$signed(C3W'(r)) : $signed(C3W'(r));
  endfunction

  function automatic logic signed [SUMW-1:0] rnd_out(input logic signed [SUMW-1:0] x);
    logic [SUMW-1:0] m;
    logic [SUMW-1:0] r;
    m = x[SUMW-1] ? SUMW'(-x) : SUMW'(x);
    r = (m + HALF_O) >> FRAC_BITS;
    return x[SUMW-1] ? -$signed(r) : $signed(r);
  endfunction

  // Configuration
  logic [CFG_W-1:0] thr_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_axis_threshold;
    end
  end

  // W = normalize(n)
  logic signed [IN_W-1:0] n_vec [3];
  dir_t                   dir_in;
  logic                   n1_valid, n1_zero;
  logic signed [VW-1:0]   w_vec [3];
  dir_t                   n1_dir;

  assign n_vec[0] = in_normal_x;
  assign n_vec[1] = in_normal_y;
  assign n_vec[2] = in_normal_z;
  assign dir_in   = '{x: in_dir_x, y: in_dir_y, z: in_dir_z};

  obt_norm #(.FRAC(FRAC_BITS), .IW(IN_W), .SW($bits(dir_t))) u_norm_w (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_vec    (n_vec),
    .in_side   (dir_in),
    .out_valid (n1_valid),
    .out_vec   (w_vec),
    .out_zero  (n1_zero),
    .out_side  (n1_dir)
  );

  // Helper axis: squared components of the distance from W to the nearest y unit vector
  logic                 h1_valid_r;
  ctx2_t                h1_ctx_r;
  logic signed [HW-1:0] h1_sq_r [3];
  logic signed [VW:0]   aw1_nxt, dy_nxt;

  always_comb begin
    aw1_nxt = w_vec[1][VW-1] ? -((VW+1)'(w_vec[1])) : (VW+1)'(w_vec[1]);
    dy_nxt  = aw1_nxt - ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_valid_r <= 1'b0;
    end else begin
      h1_valid_r <= n1_valid;
    end
    h1_ctx_r <= '{degen: n1_zero, d: n1_dir, wx: w_vec[0], wy: w_vec[1], wz: w_vec[2]};
    h1_sq_r[0] <= w_vec[0] * w_vec[0];
    h1_sq_r[1] <= dy_nxt * dy_nxt;
    h1_sq_r[2] <= w_vec[2] * w_vec[2];
  end

  // Pick helper and form W x helper
  logic                 h2_valid_r;
  ctx2_t                h2_ctx_r;
  logic signed [VW-1:0] h2_c_r [3];
  logic signed [DW-1:0] dist_nxt;
  logic                 use_x_nxt;

  always_comb begin
    dist_nxt  = DW'(h1_sq_r[0]) + DW'(h1_sq_r[1]) + DW'(h1_sq_r[2]);
    use_x_nxt = (dist_nxt < $signed({{(DW-CFG_W){1'b0}}, thr_r}))
             || (h1_ctx_r.wx == '0 && h1_ctx_r.wz == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2_valid_r <= 1'b0;
    end else begin
      h2_valid_r <= h1_valid_r;
    end
    h2_ctx_r <= h1_ctx_r;
    if (use_x_nxt) begin
      h2_c_r[0] <= '0;
      h2_c_r[1] <= h1_ctx_r.wz;
      h2_c_r[2] <= -h1_ctx_r.wy;
    end else begin
      h2_c_r[0] <= -h1_ctx_r.wz;
      h2_c_r[1] <= '0;
      h2_c_r[2] <= h1_ctx_r.wx;
    end
  end

  // U = normalize(W x helper)
  logic                 n2_valid, n2_zero;
  logic signed [VW-1:0] u_vec [3];
  ctx2_t                n2_ctx;

  obt_norm #(.FRAC(FRAC_BITS), .IW(VW), .SW($bits(ctx2_t))) u_norm_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h2_valid_r),
    .in_vec    (h2_c_r),
    .in_side   (h2_ctx_r),
    .out_valid (n2_valid),
    .out_vec   (u_vec),
    .out_zero  (n2_zero),
    .out_side  (n2_ctx)
  );

  // W x U products
  logic                  x1_valid_r;
  ctx3_t                 x1_ctx_r;
  logic signed [PXW-1:0] x1_p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_valid_r <= 1'b0;
    end else begin
      x1_valid_r <= n2_valid;
    end
    x1_ctx_r  <= '{c: n2_ctx, ux: u_vec[0], uy: u_vec[1], uz: u_vec[2]};
    x1_p_r[0] <= n2_ctx.wy * u_vec[2];
    x1_p_r[1] <= n2_ctx.wz * u_vec[1];
    x1_p_r[2] <= n2_ctx.wz * u_vec[0];
    x1_p_r[3] <= n2_ctx.wx * u_vec[2];
    x1_p_r[4] <= n2_ctx.wx * u_vec[1];
    x1_p_r[5] <= n2_ctx.wy * u_vec[0];
  end

  // Differences, rounded back to FRAC_BITS
  logic                  x2_valid_r;
  ctx3_t                 x2_ctx_r;
  logic signed [C3W-1:0] x2_c_r [3];
  logic signed [DFW-1:0] df_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df_nxt[i] = DFW'(x1_p_r[2*i]) - DFW'(x1_p_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_valid_r <= 1'b0;
    end else begin
      x2_valid_r <= x1_valid_r;
    end
    x2_ctx_r <= x1_ctx_r;
    for (int i = 0; i < 3; i++) begin
      x2_c_r[i] <= rnd_cross(df_nxt[i]);
    end
  end

  // V = normalize(W x U)
  logic                 n3_valid, n3_zero;
  logic signed [VW-1:0] v_vec [3];
  ctx3_t                n3_ctx;

  obt_norm #(.FRAC(FRAC_BITS), .IW(C3W), .SW($bits(ctx3_t))) u_norm_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (x2_valid_r),
    .in_vec    (x2_c_r),
    .in_side   (x2_ctx_r),
    .out_valid (n3_valid),
    .out_vec   (v_vec),
    .out_zero  (n3_zero),
    .out_side  (n3_ctx)
  );

  // Basis times direction
  logic                 p_valid_r;
  logic                 p_degen_r;
  logic signed [PW-1:0] p_prod_r [3][3];
  logic signed [VW-1:0] bu [3];
  logic signed [VW-1:0] bw [3];

  assign bu[0] = n3_ctx.ux;
  assign bu[1] = n3_ctx.uy;
  assign bu[2] = n3_ctx.uz;
  assign bw[0] = n3_ctx.c.wx;
  assign bw[1] = n3_ctx.c.wy;
  assign bw[2] = n3_ctx.c.wz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= n3_valid;
    end
    p_degen_r <= n3_ctx.c.degen;
    for (int i = 0; i < 3; i++) begin
      p_prod_r[i][0] <= bu[i] * n3_ctx.c.d.x;
      p_prod_r[i][1] <= v_vec[i] * n3_ctx.c.d.y;
      p_prod_r[i][2] <= bw[i] * n3_ctx.c.d.z;
    end
  end

  // Sum, round, saturate
  logic                    out_valid_r;
  logic                    out_degen_r;
  logic signed [OUT_W-1:0] out_r [3];
  logic signed [SUMW-1:0]  sum_nxt [3];
  logic signed [SUMW-1:0]  rnd_nxt [3];
  logic signed [OUT_W-1:0] sat_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = SUMW'(p_prod_r[i][0]) + SUMW'(p_prod_r[i][1]) + SUMW'(p_prod_r[i][2]);
      rnd_nxt[i] = rnd_out(sum_nxt[i]);
      if (p_degen_r) begin
        sat_nxt[i] = '0;
      end else if (rnd_nxt[i] > SAT_HI) begin
        sat_nxt[i] = OUT_W'(SAT_HI);
      end else if (rnd_nxt[i] < SAT_LO) begin
        sat_nxt[i] = OUT_W'(SAT_LO);
      end else begin
        sat_nxt[i] = OUT_W'(rnd_nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_degen_r <= 1'b0;
    end else begin
      out_valid_r <= p_valid_r;
      out_degen_r <= p_valid_r && p_degen_r;
    end
    for (int i = 0; i < 3; i++) begin
      out_r[i] <= sat_nxt[i];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = out_degen_r;
  assign out_x          = out_r[0];
  assign out_y          = out_r[1];
  assign out_z          = out_r[2];

  // The later normalizers see a zero vector only on a word whose normal is zero, which is already flagged degenerate.
  logic unused_zero;
  assign unused_zero = n2_zero ^ n3_zero;

endmodule

// ===== rtl/core/obt_checker.sv =====
module obt_props import obt_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic signed [OUT_W-1:0] out_x,
  input logic signed [OUT_W-1:0] out_y,
  input logic signed [OUT_W-1:0] out_z,
  input logic                    out_degenerate
);

  localparam int LAT = obt_latency(FRAC_BITS);

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted word produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT !out_valid)
    else $error("result without accepted word");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("degenerate result not zero");

  a_degen_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_degenerate |-> out_valid)
    else $error("degenerate flag outside strobe");

endmodule

bind orthonormal_basis_transform obt_props #(.FRAC_BITS(FRAC_BITS)) u_obt_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_x          (out_x),
  .out_y          (out_y),
  .out_z          (out_z),
  .out_degenerate (out_degenerate)
);
